@@ sv/harmonic_bond_force_macros.svh @@
// ----------------------------------------------------------------------------
// Harmonic bond force assertion macros
// Shared concurrent assertion forms for the bond force block.
// ----------------------------------------------------------------------------
`ifndef HARMONIC_BOND_FORCE_MACROS_SVH
`define HARMONIC_BOND_FORCE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define HBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hbf_pkg.sv @@
// ----------------------------------------------------------------------------
// hbf_pkg
// Constants, opcodes and fixed-point helpers of the bond force block.
// ----------------------------------------------------------------------------
package hbf_pkg;

  localparam int NUM_ATOMS = 4096;
  localparam int ATOM_AW   = $clog2(NUM_ATOMS);
  localparam int FORCE_W   = 192;

  localparam logic [1:0] OP_BOND  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_BOX_X  = 3'd0;
  localparam logic [2:0] REG_BOX_Y  = 3'd1;
  localparam logic [2:0] REG_BOX_Z  = 3'd2;
  localparam logic [2:0] REG_HALF_X = 3'd3;
  localparam logic [2:0] REG_HALF_Y = 3'd4;
  localparam logic [2:0] REG_HALF_Z = 3'd5;

  localparam logic [63:0] POS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;

  // Unit handshake between the sequencer and an arithmetic unit.
  typedef struct packed {
    logic start;
  } hbf_unit_req_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? $signed(NEG_CAP) : $signed(POS_CAP);
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] signed_from(input logic [63:0] mag,
                                                     input logic neg);
    if (neg) begin
      if (mag >= NEG_CAP) return $signed(NEG_CAP);
      return $signed(64'd0 - mag);
    end
    if (mag > POS_CAP) return $signed(POS_CAP);
    return $signed(mag);
  endfunction

  // Product shifted down by 16, clipped to the signed range of its sign.
  function automatic logic [63:0] shr16_cap(input logic [95:0] p, input logic neg);
    logic [63:0] cap;
    cap = neg ? NEG_CAP : POS_CAP;
    if (p[95:80] != 16'd0) return cap;
    if (p[79:16] > cap) return cap;
    return p[79:16];
  endfunction

  // Quotient clipped to the signed range of its sign.
  function automatic logic [63:0] quot_cap(input logic [95:0] q, input logic neg);
    logic [63:0] cap;
    cap = neg ? NEG_CAP : POS_CAP;
    if (q[95:64] != 32'd0) return cap;
    if (q[63:0] > cap) return cap;
    return q[63:0];
  endfunction

  // Minimum image on one axis, then clip to Q16.16.
  function automatic logic signed [31:0] img_axis(input logic signed [31:0] pa,
                                                  input logic signed [31:0] pb,
                                                  input logic [30:0] len,
                                                  input logic [30:0] half);
    logic signed [33:0] dd;
    logic signed [33:0] h;
    logic signed [33:0] l;
    dd = 34'(pb) - 34'(pa);
    h  = $signed({3'b000, half});
    l  = $signed({3'b000, len});
    if (dd > h) dd = dd - l;
    else if (dd < -h) dd = dd + l;
    if (dd[33:31] != 3'b000 && dd[33:31] != 3'b111)
      return dd[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return dd[31:0];
  endfunction

  // Operand order of the six virial terms: xx, yx, yy, zx, zy, zz.
  function automatic logic [1:0] vir_f_idx(input logic [2:0] j);
    case (j)
      3'd0:          return 2'd0;
      3'd1, 3'd2:    return 2'd1;
      default:       return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] vir_d_idx(input logic [2:0] j);
    case (j)
      3'd2, 3'd4: return 2'd1;
      3'd5:       return 2'd2;
      default:    return 2'd0;
    endcase
  endfunction

endpackage

@@ sv/hbf_ram.sv @@
// ----------------------------------------------------------------------------
// hbf_ram
// Simple dual-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module hbf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 192,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/hbf_mul.sv @@
// ----------------------------------------------------------------------------
// hbf_mul
// 64 x 32 unsigned multiplier from two 32 x 32 partial products.
// ----------------------------------------------------------------------------
module hbf_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hbf_pkg::hbf_unit_req_t req,
  input  logic [63:0]            a,
  input  logic [31:0]            b,
  output logic [95:0]            p,
  output logic                   done
);

  logic [1:0]  stage_r, stage_nxt;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [63:0] pl_r;
  logic [63:0] ph_r;
  logic [95:0] p_r;
  logic        done_r, done_nxt;

  always_comb begin
    stage_nxt = stage_r;
    done_nxt  = 1'b0;
    case (stage_r)
      2'd0:    if (req.start) stage_nxt = 2'd1;
      2'd3: begin
        stage_nxt = 2'd0;
        done_nxt  = 1'b1;
      end
      default: stage_nxt = stage_r + 2'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_r == 2'd0 && req.start) begin
      a_r <= a;
      b_r <= b;
    end
    if (stage_r == 2'd1) pl_r <= a_r[31:0] * b_r;
    if (stage_r == 2'd2) ph_r <= a_r[63:32] * b_r;
    if (stage_r == 2'd3) p_r  <= {ph_r, 32'd0} + {32'd0, pl_r};
  end

  assign p    = p_r;
  assign done = done_r;

endmodule

@@ sv/hbf_isqrt.sv @@
// ----------------------------------------------------------------------------
// hbf_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module hbf_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hbf_pkg::hbf_unit_req_t req,
  input  logic [63:0]            rad,
  output logic [31:0]            root,
  output logic                   done
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] rad_r;
  logic [32:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  assign rem_sh = {rem_r, rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (cnt_r == 6'd0) begin
      if (req.start) cnt_nxt = 6'd32;
    end else begin
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == 6'd0) begin
      if (req.start) begin
        rad_r  <= rad;
        rem_r  <= 33'd0;
        root_r <= 32'd0;
      end
    end else begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= 33'(rem_sh - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[32:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

@@ sv/hbf_div.sv @@
// ----------------------------------------------------------------------------
// hbf_div
// Restoring divider, 96-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module hbf_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hbf_pkg::hbf_unit_req_t req,
  input  logic [95:0]            dividend,
  input  logic [31:0]            divisor,
  output logic [95:0]            quot,
  output logic                   done
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [95:0] dvd_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [32:0] rem_sh;
  logic        q_bit;

  assign rem_sh = {rem_r, dvd_r[95]};
  assign q_bit  = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (cnt_r == 7'd0) begin
      if (req.start) cnt_nxt = 7'd96;
    end else begin
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 7'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == 7'd0) begin
      if (req.start) begin
        dvd_r <= dividend;
        dsr_r <= divisor;
        rem_r <= 32'd0;
      end
    end else begin
      dvd_r <= {dvd_r[94:0], q_bit};
      rem_r <= q_bit ? 32'(rem_sh - {1'b0, dsr_r}) : rem_sh[31:0];
    end
  end

  assign quot = dvd_r;
  assign done = done_r;

endmodule

@@ sv/harmonic_bond_force.sv @@
// Throughput: one item at a time; a bond is dominated by the 96-step divider
// run once per axis, plus the 32-step square root and fifteen shared multiplies.
// Reset: synchronous; then a clearing pass over all NUM_ATOMS entries zeroes
// the force store, with the input stalled (configuration writes still taken).
// ----------------------------------------------------------------------------
// harmonic_bond_force
// Harmonic bond stretch force with a per-atom force store in block RAM,
// saturating Q32.32 energy and virial accumulators, minimum image per axis.
// ----------------------------------------------------------------------------
`include "harmonic_bond_force_macros.svh"

module harmonic_bond_force (
  input  logic               clk,
  input  logic               rst_n,
  // bond / command input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [11:0]        in_first_atom,
  input  logic [11:0]        in_second_atom,
  input  logic signed [31:0] in_first_pos_x,
  input  logic signed [31:0] in_first_pos_y,
  input  logic signed [31:0] in_first_pos_z,
  input  logic signed [31:0] in_second_pos_x,
  input  logic signed [31:0] in_second_pos_y,
  input  logic signed [31:0] in_second_pos_z,
  input  logic [30:0]        in_rest_length,
  input  logic [31:0]        in_stiffness,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_energy_sum,
  output logic signed [63:0] out_force_out_x,
  output logic signed [63:0] out_force_out_y,
  output logic signed [63:0] out_force_out_z,
  output logic signed [63:0] out_virial_xx,
  output logic signed [63:0] out_virial_yx,
  output logic signed [63:0] out_virial_yy,
  output logic signed [63:0] out_virial_zx,
  output logic signed [63:0] out_virial_zy,
  output logic signed [63:0] out_virial_zz,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int AW = hbf_pkg::ATOM_AW;
  localparam int FW = hbf_pkg::FORCE_W;

  // Sequencer states
  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_IMG  = 5'd2;
  localparam logic [4:0] ST_SQ   = 5'd3;
  localparam logic [4:0] ST_SQRT = 5'd4;
  localparam logic [4:0] ST_DR   = 5'd5;
  localparam logic [4:0] ST_RR   = 5'd6;
  localparam logic [4:0] ST_KE   = 5'd7;
  localparam logic [4:0] ST_KP   = 5'd8;
  localparam logic [4:0] ST_FM   = 5'd9;
  localparam logic [4:0] ST_FD   = 5'd10;
  localparam logic [4:0] ST_VIR  = 5'd11;
  localparam logic [4:0] ST_RDA  = 5'd12;
  localparam logic [4:0] ST_WRA  = 5'd13;
  localparam logic [4:0] ST_RDB  = 5'd14;
  localparam logic [4:0] ST_WRB  = 5'd15;
  localparam logic [4:0] ST_RD1  = 5'd16;
  localparam logic [4:0] ST_WR1  = 5'd17;
  localparam logic [4:0] ST_OUT  = 5'd18;

  // Control state
  logic [4:0]  st_r, st_nxt;
  logic        go_r, go_nxt;
  logic [2:0]  j_r, j_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Configuration registers
  logic [30:0] box_r  [3];
  logic [30:0] half_r [3];

  // Item and datapath registers
  logic [1:0]  op_r, op_nxt;
  logic [11:0] ia_r, ia_nxt;
  logic [11:0] ib_r, ib_nxt;
  logic signed [31:0] pa_r [3];
  logic signed [31:0] pa_nxt [3];
  logic signed [31:0] pb_r [3];
  logic signed [31:0] pb_nxt [3];
  logic [30:0] req_r, req_nxt;
  logic [31:0] k_r, k_nxt;
  logic signed [31:0] d_r [3];
  logic signed [31:0] d_nxt [3];
  logic [63:0] r2_r, r2_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] mrr_r, mrr_nxt;
  logic        frneg_r, frneg_nxt;
  logic [63:0] rr2_r, rr2_nxt;
  logic [63:0] frm_r, frm_nxt;
  logic [95:0] prod_r, prod_nxt;
  logic signed [63:0] f_r [3];
  logic signed [63:0] f_nxt [3];
  logic signed [63:0] energy_r, energy_nxt;
  logic signed [63:0] vir_r [6];
  logic signed [63:0] vir_nxt [6];

  // Output register
  logic signed [63:0] o_energy_r;
  logic signed [63:0] o_f_r [3];
  logic signed [63:0] o_vir_r [6];
  logic               out_load;

  // Units
  hbf_pkg::hbf_unit_req_t mul_req, sq_req, dv_req;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] mul_p;
  logic        mul_done;
  logic [31:0] sq_root;
  logic        sq_done;
  logic [95:0] dv_q;
  logic        dv_done;

  // Force store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [FW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [FW-1:0] ram_rdata;

  // Operand selection
  logic [1:0]         d_idx;
  logic [1:0]         f_idx;
  logic signed [31:0] d_sel;
  logic [32:0]        d_neg;
  logic [31:0]        dmag_sel;
  logic signed [63:0] f_sel;
  logic [64:0]        f_neg;
  logic [63:0]        fmag_sel;
  logic               fr_neg;
  logic               ia_ok;
  logic               ib_ok;
  logic               accept;
  logic signed [33:0] dr;

  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign ia_ok     = ({20'd0, ia_r} < 32'(hbf_pkg::NUM_ATOMS));
  assign ib_ok     = ({20'd0, ib_r} < 32'(hbf_pkg::NUM_ATOMS));
  assign fr_neg    = frneg_r && (frm_r != 64'd0);
  assign dr        = $signed({2'b00, r_r}) - $signed({3'b000, req_r});

  // Pick the axis operands for the shared multiplier
  always_comb begin
    d_idx = j_r[1:0];
    f_idx = 2'd0;
    if (st_r == ST_VIR) begin
      d_idx = hbf_pkg::vir_d_idx(j_r);
      f_idx = hbf_pkg::vir_f_idx(j_r);
    end
  end

  assign d_sel    = d_r[d_idx];
  assign d_neg    = 33'd0 - {d_sel[31], d_sel};
  assign dmag_sel = d_sel[31] ? d_neg[31:0] : d_sel;
  assign f_sel    = f_r[f_idx];
  assign f_neg    = 65'd0 - {f_sel[63], f_sel};
  assign fmag_sel = f_sel[63] ? f_neg[63:0] : f_sel;

  always_comb begin
    mul_a = 64'd0;
    mul_b = 32'd0;
    case (st_r)
      ST_SQ: begin
        mul_a = {32'd0, dmag_sel};
        mul_b = dmag_sel;
      end
      ST_RR: begin
        mul_a = {32'd0, mrr_r};
        mul_b = mrr_r;
      end
      ST_KE: begin
        mul_a = rr2_r;
        mul_b = k_r;
      end
      ST_KP: begin
        mul_a = {32'd0, mrr_r};
        mul_b = k_r;
      end
      ST_FM: begin
        mul_a = frm_r;
        mul_b = dmag_sel;
      end
      ST_VIR: begin
        mul_a = fmag_sel;
        mul_b = dmag_sel;
      end
      default: begin
        mul_a = 64'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Issue each unit once per wait state
  assign mul_req.start = !go_r && (st_r == ST_SQ || st_r == ST_RR || st_r == ST_KE ||
                                   st_r == ST_KP || st_r == ST_FM || st_r == ST_VIR);
  assign sq_req.start  = !go_r && (st_r == ST_SQRT);
  assign dv_req.start  = !go_r && (st_r == ST_FD);

  assign out_load = (st_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Main sequencer
  always_comb begin
    logic neg;
    logic signed [63:0] nf [3];
    logic [63:0] p64;
    logic [63:0] cap;
    neg         = 1'b0;
    p64         = 64'd0;
    cap         = hbf_pkg::POS_CAP;
    st_nxt      = st_r;
    go_nxt      = go_r;
    j_nxt       = j_r;
    clr_cnt_nxt = clr_cnt_r;
    op_nxt      = op_r;
    ia_nxt      = ia_r;
    ib_nxt      = ib_r;
    pa_nxt      = pa_r;
    pb_nxt      = pb_r;
    req_nxt     = req_r;
    k_nxt       = k_r;
    d_nxt       = d_r;
    r2_nxt      = r2_r;
    r_nxt       = r_r;
    mrr_nxt     = mrr_r;
    frneg_nxt   = frneg_r;
    rr2_nxt     = rr2_r;
    frm_nxt     = frm_r;
    prod_nxt    = prod_r;
    f_nxt       = f_r;
    energy_nxt  = energy_r;
    vir_nxt     = vir_r;
    ram_we      = 1'b0;
    ram_waddr   = AW'(ia_r);
    ram_wdata   = '0;
    ram_raddr   = AW'(ia_r);
    for (int i = 0; i < 3; i++) begin
      nf[i] = (f_r[i] == $signed(hbf_pkg::NEG_CAP)) ? $signed(hbf_pkg::POS_CAP) : -f_r[i];
    end

    unique case (st_r)
      ST_CLR: begin
        // Sweep the force store to zero after reset
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(hbf_pkg::NUM_ATOMS - 1)) st_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          ia_nxt    = in_first_atom;
          ib_nxt    = in_second_atom;
          pa_nxt[0] = in_first_pos_x;
          pa_nxt[1] = in_first_pos_y;
          pa_nxt[2] = in_first_pos_z;
          pb_nxt[0] = in_second_pos_x;
          pb_nxt[1] = in_second_pos_y;
          pb_nxt[2] = in_second_pos_z;
          req_nxt   = in_rest_length;
          k_nxt     = in_stiffness;
          for (int i = 0; i < 3; i++) f_nxt[i] = '0;
          case (in_opcode)
            hbf_pkg::OP_BOND: st_nxt = ST_IMG;
            hbf_pkg::OP_READ: st_nxt = ST_RD1;
            hbf_pkg::OP_CLEAR: begin
              energy_nxt = '0;
              for (int i = 0; i < 6; i++) vir_nxt[i] = '0;
              st_nxt = ST_OUT;
            end
            default: st_nxt = ST_OUT;
          endcase
        end
      end

      ST_IMG: begin
        for (int i = 0; i < 3; i++) begin
          d_nxt[i] = hbf_pkg::img_axis(pa_r[i], pb_r[i], box_r[i], half_r[i]);
        end
        r2_nxt = 64'd0;
        j_nxt  = 3'd0;
        st_nxt = ST_SQ;
      end

      ST_SQ: begin
        if (!go_r) go_nxt = 1'b1;
        else if (mul_done) begin
          go_nxt = 1'b0;
          r2_nxt = r2_r + mul_p[63:0];
          if (j_r == 3'd2) begin
            j_nxt  = 3'd0;
            st_nxt = ST_SQRT;
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end
      end

      ST_SQRT: begin
        if (!go_r) go_nxt = 1'b1;
        else if (sq_done) begin
          go_nxt = 1'b0;
          r_nxt  = sq_root;
          st_nxt = ST_DR;
        end
      end

      ST_DR: begin
        frneg_nxt = (dr > 34'sd0);
        mrr_nxt   = dr[33] ? 32'(-dr) : dr[31:0];
        st_nxt    = ST_RR;
      end

      ST_RR: begin
        if (!go_r) go_nxt = 1'b1;
        else if (mul_done) begin
          go_nxt  = 1'b0;
          rr2_nxt = mul_p[63:0];
          st_nxt  = ST_KE;
        end
      end

      ST_KE: begin
        if (!go_r) go_nxt = 1'b1;
        else if (mul_done) begin
          go_nxt     = 1'b0;
          energy_nxt = hbf_pkg::sat_add(energy_r,
                                        $signed(hbf_pkg::shr16_cap(mul_p, 1'b0)));
          st_nxt     = ST_KP;
        end
      end

      ST_KP: begin
        if (!go_r) go_nxt = 1'b1;
        else if (mul_done) begin
          go_nxt = 1'b0;
          // Double k*|dr| and clip to the range of its sign
          p64 = mul_p[63:0];
          cap = frneg_r ? hbf_pkg::NEG_CAP : hbf_pkg::POS_CAP;
          if (p64[63]) frm_nxt = cap;
          else if ({p64[62:0], 1'b0} > cap) frm_nxt = cap;
          else frm_nxt = {p64[62:0], 1'b0};
          j_nxt = 3'd0;
          // Zero length: no force and no virial
          st_nxt = (r_r == 32'd0) ? ST_OUT : ST_FM;
        end
      end

      ST_FM: begin
        if (!go_r) go_nxt = 1'b1;
        else if (mul_done) begin
          go_nxt   = 1'b0;
          prod_nxt = mul_p;
          st_nxt   = ST_FD;
        end
      end

      ST_FD: begin
        if (!go_r) go_nxt = 1'b1;
        else if (dv_done) begin
          go_nxt          = 1'b0;
          neg             = fr_neg ^ d_r[j_r[1:0]][31];
          f_nxt[j_r[1:0]] = hbf_pkg::signed_from(hbf_pkg::quot_cap(dv_q, neg), neg);
          if (j_r == 3'd2) begin
            j_nxt  = 3'd0;
            st_nxt = ST_VIR;
          end else begin
            j_nxt  = j_r + 3'd1;
            st_nxt = ST_FM;
          end
        end
      end

      ST_VIR: begin
        if (!go_r) go_nxt = 1'b1;
        else if (mul_done) begin
          go_nxt     = 1'b0;
          neg        = f_sel[63] ^ d_sel[31];
          vir_nxt[j_r] = hbf_pkg::sat_add(vir_r[j_r],
                           hbf_pkg::signed_from(hbf_pkg::shr16_cap(mul_p, neg), neg));
          if (j_r == 3'd5) begin
            j_nxt  = 3'd0;
            st_nxt = ST_RDA;
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end
      end

      ST_RDA: begin
        ram_raddr = AW'(ia_r);
        st_nxt    = ST_WRA;
      end

      ST_WRA: begin
        // Subtract the bond force from the first atom
        ram_we    = ia_ok;
        ram_waddr = AW'(ia_r);
        ram_wdata = {hbf_pkg::sat_add($signed(ram_rdata[191:128]), nf[2]),
                     hbf_pkg::sat_add($signed(ram_rdata[127:64]),  nf[1]),
                     hbf_pkg::sat_add($signed(ram_rdata[63:0]),    nf[0])};
        st_nxt    = ST_RDB;
      end

      ST_RDB: begin
        ram_raddr = AW'(ib_r);
        st_nxt    = ST_WRB;
      end

      ST_WRB: begin
        // Add the bond force to the second atom
        ram_we    = ib_ok;
        ram_waddr = AW'(ib_r);
        ram_wdata = {hbf_pkg::sat_add($signed(ram_rdata[191:128]), f_r[2]),
                     hbf_pkg::sat_add($signed(ram_rdata[127:64]),  f_r[1]),
                     hbf_pkg::sat_add($signed(ram_rdata[63:0]),    f_r[0])};
        st_nxt    = ST_OUT;
      end

      ST_RD1: begin
        ram_raddr = AW'(ia_r);
        st_nxt    = ST_WR1;
      end

      ST_WR1: begin
        // Report the atom's force and drop it from the store
        if (ia_ok) begin
          f_nxt[0] = $signed(ram_rdata[63:0]);
          f_nxt[1] = $signed(ram_rdata[127:64]);
          f_nxt[2] = $signed(ram_rdata[191:128]);
        end
        ram_we    = ia_ok;
        ram_waddr = AW'(ia_r);
        ram_wdata = '0;
        st_nxt    = ST_OUT;
      end

      ST_OUT: begin
        if (out_load) st_nxt = ST_IDLE;
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      go_r        <= 1'b0;
      j_r         <= 3'd0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      energy_r    <= '0;
      for (int i = 0; i < 6; i++) vir_r[i] <= '0;
    end else begin
      st_r        <= st_nxt;
      go_r        <= go_nxt;
      j_r         <= j_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      energy_r    <= energy_nxt;
      vir_r       <= vir_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        box_r[i]  <= '0;
        half_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hbf_pkg::REG_BOX_X:  box_r[0]  <= cfg_data;
        hbf_pkg::REG_BOX_Y:  box_r[1]  <= cfg_data;
        hbf_pkg::REG_BOX_Z:  box_r[2]  <= cfg_data;
        hbf_pkg::REG_HALF_X: half_r[0] <= cfg_data;
        hbf_pkg::REG_HALF_Y: half_r[1] <= cfg_data;
        hbf_pkg::REG_HALF_Z: half_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    ia_r    <= ia_nxt;
    ib_r    <= ib_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    req_r   <= req_nxt;
    k_r     <= k_nxt;
    d_r     <= d_nxt;
    r2_r    <= r2_nxt;
    r_r     <= r_nxt;
    mrr_r   <= mrr_nxt;
    frneg_r <= frneg_nxt;
    rr2_r   <= rr2_nxt;
    frm_r   <= frm_nxt;
    prod_r  <= prod_nxt;
    f_r     <= f_nxt;
    if (out_load) begin
      o_energy_r <= energy_r;
      o_f_r      <= f_r;
      o_vir_r    <= vir_r;
    end
  end

  hbf_ram #(
    .DEPTH (hbf_pkg::NUM_ATOMS),
    .WIDTH (FW),
    .AW    (AW)
  ) u_force_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hbf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  hbf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rad   (r2_r),
    .root  (sq_root),
    .done  (sq_done)
  );

  hbf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dv_req),
    .dividend (prod_r),
    .divisor  (r_r),
    .quot     (dv_q),
    .done     (dv_done)
  );

  // Outputs
  assign out_valid       = out_valid_r;
  assign out_energy_sum  = o_energy_r;
  assign out_force_out_x = o_f_r[0];
  assign out_force_out_y = o_f_r[1];
  assign out_force_out_z = o_f_r[2];
  assign out_virial_xx   = o_vir_r[0];
  assign out_virial_yx   = o_vir_r[1];
  assign out_virial_yy   = o_vir_r[2];
  assign out_virial_zx   = o_vir_r[3];
  assign out_virial_zy   = o_vir_r[4];
  assign out_virial_zz   = o_vir_r[5];

  // Checks
  `HBF_ASSERT_NEXT(a_accept_busy, accept, st_r != ST_IDLE, "item transfer did not start work")
  `HBF_ASSERT_NOW(a_result_src, $rose(out_valid_r), $past(st_r == ST_OUT), "result without finish")
  `HBF_ASSERT_NOW(a_ram_write_st, ram_we, st_r == ST_CLR || st_r == ST_WRA || st_r == ST_WRB || st_r == ST_WR1, "stray force store write")

endmodule
